// ===== rtl/dfa_pkg.sv =====
// shared types, field widths and codes of the automaton acceptor
// no dependencies; used by every rtl file of the block except dfa_ram
package dfa_pkg;

   localparam int NODES_DEF       = 16;
   localparam int SLOTS_DEF       = 8;
   localparam int SYMBOL_BITS_DEF = 8;

   localparam int OP_W      = 2;
   localparam int NODE_W    = 4;
   localparam int SLOT_W    = 3;
   localparam int SYM_W     = 8;
   localparam int MASK_W    = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   typedef enum logic [OP_W-1:0] {
      OP_EDGE = 2'd0,
      OP_FEED = 2'd1,
      OP_END  = 2'd2
   } op_type;

   localparam logic [CSR_IDX_W-1:0] CSR_START  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEPT = 2'd1;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EVAL = 2'b10
   } state_type;

   typedef struct packed {
      logic              hit;
      logic [NODE_W-1:0] next;
   } match_type;

endpackage

// ===== rtl/dfa_channels.sv =====
// valid/ready channel interfaces: symbol/edge requests, results, register writes
// depends on dfa_pkg for field widths
interface dfa_req_if;
   logic                         valid;
   logic                         ready;
   logic [dfa_pkg::OP_W-1:0]     op;
   logic [dfa_pkg::SYM_W-1:0]    symbol;
   logic                         last;
   logic [dfa_pkg::NODE_W-1:0]   edge_node;
   logic [dfa_pkg::SLOT_W-1:0]   edge_slot;
   logic [dfa_pkg::SYM_W-1:0]    edge_symbol;
   logic [dfa_pkg::NODE_W-1:0]   edge_next;
   logic                         edge_enable;

   modport source (output valid, op, symbol, last, edge_node, edge_slot, edge_symbol,
                   edge_next, edge_enable, input ready);
   modport sink   (input valid, op, symbol, last, edge_node, edge_slot, edge_symbol,
                   edge_next, edge_enable, output ready);
endinterface

interface dfa_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       accepted;
   logic                       dead_end;
   logic [dfa_pkg::NODE_W-1:0] final_node;

   modport source (output valid, accepted, dead_end, final_node, input ready);
   modport sink   (input valid, accepted, dead_end, final_node, output ready);
endinterface

interface dfa_csr_if;
   logic                          valid;
   logic                          ready;
   logic [dfa_pkg::CSR_IDX_W-1:0] index;
   logic [dfa_pkg::CSR_DAT_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/dfa_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module dfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/dfa_row_match.sv =====
// compares a symbol against all slots of one transition row, lowest valid hit wins
// depends on dfa_pkg (match_type, node width)
module dfa_row_match #(
   parameter int SLOTS       = dfa_pkg::SLOTS_DEF,
   parameter int SYMBOL_BITS = dfa_pkg::SYMBOL_BITS_DEF
) (
   input  logic [SLOTS*(SYMBOL_BITS+1+dfa_pkg::NODE_W)-1:0] row,
   input  logic [SYMBOL_BITS-1:0]                           sym,
   output dfa_pkg::match_type                               result
);

   localparam int ENTRY_W = SYMBOL_BITS + 1 + dfa_pkg::NODE_W;

   logic [SLOTS-1:0] hit_vec;

   always_comb begin
      for (int s = 0; s < SLOTS; s++) begin
         hit_vec[s] = row[s*ENTRY_W + dfa_pkg::NODE_W + SYMBOL_BITS] &&
                      (row[s*ENTRY_W + dfa_pkg::NODE_W +: SYMBOL_BITS] == sym);
      end
   end

   // walk from the top down so the lowest hit is the one left standing
   always_comb begin
      result.hit  = |hit_vec;
      result.next = '0;
      for (int s = SLOTS - 1; s >= 0; s--) begin
         if (hit_vec[s]) begin
            result.next = row[s*ENTRY_W +: dfa_pkg::NODE_W];
         end
      end
   end

endmodule

// ===== rtl/dfa_acceptor_unit.sv =====
// automaton acceptor: one ram row per node holding all edge slots, row match logic
// a transfer registers the item and reads a row from ram (the walk node's, or the edge node's
// for an edge write); the slot compare/write-back then completes it; no new item is taken before
// that; an ending item stalls in evaluation while an earlier result is still held
// reset (synchronous): walk restarts at node 0, all edge rows invalid, start and accept mask zero, no result
// depends on dfa_pkg, dfa_channels, dfa_ram, dfa_row_match
module dfa_acceptor_unit #(
   parameter int NODES       = dfa_pkg::NODES_DEF,
   parameter int SLOTS       = dfa_pkg::SLOTS_DEF,
   parameter int SYMBOL_BITS = dfa_pkg::SYMBOL_BITS_DEF
) (
   input logic      clock,
   input logic      reset,
   dfa_req_if.sink  req_ch,
   dfa_rsp_if.source rsp_ch,
   dfa_csr_if.sink  csr_ch
);

   localparam int NODE_W   = dfa_pkg::NODE_W;
   localparam int ROW_W    = $clog2(NODES);
   localparam int ENTRY_W  = SYMBOL_BITS + 1 + NODE_W;
   localparam int ROW_BITS = SLOTS * ENTRY_W;

   // configuration
   logic [NODE_W-1:0]          start_ff;
   logic [dfa_pkg::MASK_W-1:0] mask_ff;

   // walk state
   logic [NODE_W-1:0] cur_ff, cur_in;
   logic              dead_ff, dead_in;
   logic              fresh_ff, fresh_in;
   logic [NODES-1:0]  row_valid_ff, row_valid_in;
   dfa_pkg::state_type state_ff, state_in;

   // item held during evaluation
   logic [dfa_pkg::OP_W-1:0]   op_ff;
   logic                       last_ff;
   logic [SYMBOL_BITS-1:0]     sym_ff;
   logic [dfa_pkg::SLOT_W-1:0] eslot_ff;
   logic [SYMBOL_BITS-1:0]     esym_ff;
   logic [NODE_W-1:0]          enext_ff;
   logic                       en_ff;
   logic                       write_ok_ff;
   logic [NODE_W-1:0]          node_ff;
   logic [ROW_W-1:0]           addr_ff;
   logic                       row_live_ff;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              acc_ff, acc_in;
   logic              dend_ff, dend_in;
   logic [NODE_W-1:0] fnode_ff, fnode_in;

   logic              accept;
   logic [NODE_W-1:0] walk_node;
   logic [NODE_W-1:0] look_node;
   logic [ROW_W-1:0]  rd_addr;
   logic              node_ok;
   logic [ROW_BITS-1:0] rd_row, eff_row, wr_row;
   logic              ram_we;
   logic              need_rsp, done;
   logic              fin;
   logic [NODE_W-1:0] fin_node;
   logic              fin_dead;
   dfa_pkg::match_type match;

   assign req_ch.ready = (state_ff == dfa_pkg::ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   assign walk_node = fresh_ff ? start_ff : cur_ff;
   assign look_node = (req_ch.op == dfa_pkg::OP_EDGE) ? req_ch.edge_node : walk_node;
   assign rd_addr   = ROW_W'(look_node);
   assign node_ok   = int'(look_node) < NODES;

   dfa_ram #(.WIDTH(ROW_BITS), .DEPTH(NODES)) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (addr_ff),
      .wdata (wr_row),
      .re    (accept),
      .raddr (rd_addr),
      .rdata (rd_row)
   );

   // a row never written reads as all slots invalid
   always_comb begin
      eff_row = rd_row;
      for (int s = 0; s < SLOTS; s++) begin
         if (!row_live_ff) begin
            eff_row[s*ENTRY_W + NODE_W + SYMBOL_BITS] = 1'b0;
         end
      end
   end

   // merge the written slot into the row; clearing keeps symbol and next
   always_comb begin
      wr_row = eff_row;
      for (int s = 0; s < SLOTS; s++) begin
         if (int'(eslot_ff) == s) begin
            wr_row[s*ENTRY_W + NODE_W + SYMBOL_BITS] = en_ff;
            if (en_ff) begin
               wr_row[s*ENTRY_W + NODE_W +: SYMBOL_BITS] = esym_ff;
               wr_row[s*ENTRY_W +: NODE_W]               = enext_ff;
            end
         end
      end
   end

   dfa_row_match #(.SLOTS(SLOTS), .SYMBOL_BITS(SYMBOL_BITS)) u_match (
      .row    (eff_row),
      .sym    (sym_ff),
      .result (match)
   );

   assign need_rsp = ((op_ff == dfa_pkg::OP_FEED) && last_ff) || (op_ff == dfa_pkg::OP_END);
   assign done     = (state_ff == dfa_pkg::ST_EVAL) &&
                     (!need_rsp || !rsp_valid_ff || rsp_ch.ready);
   assign ram_we   = done && (op_ff == dfa_pkg::OP_EDGE) && write_ok_ff;

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      dead_in      = dead_ff;
      fresh_in     = fresh_ff;
      row_valid_in = row_valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      acc_in       = acc_ff;
      dend_in      = dend_ff;
      fnode_in     = fnode_ff;
      fin          = 1'b0;
      fin_node     = node_ff;
      fin_dead     = dead_ff;

      case (state_ff)
         dfa_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = dfa_pkg::ST_EVAL;
            end
         end
         dfa_pkg::ST_EVAL: begin
            if (done) begin
               state_in = dfa_pkg::ST_IDLE;
               case (op_ff)
                  dfa_pkg::OP_EDGE: begin
                     if (write_ok_ff) begin
                        row_valid_in[addr_ff] = 1'b1;
                     end
                  end
                  dfa_pkg::OP_FEED: begin
                     fresh_in = 1'b0;
                     fin_node = node_ff;
                     if (!dead_ff) begin
                        if (match.hit) begin
                           fin_node = match.next;
                        end else begin
                           fin_dead = 1'b1;
                        end
                     end
                     cur_in  = fin_node;
                     dead_in = fin_dead;
                     fin     = last_ff;
                  end
                  dfa_pkg::OP_END: begin
                     fin = 1'b1;
                  end
                  default: begin
                  end
               endcase
               if (fin) begin
                  rsp_valid_in = 1'b1;
                  acc_in       = !fin_dead && mask_ff[fin_node];
                  dend_in      = fin_dead;
                  fnode_in     = fin_dead ? '0 : fin_node;
                  cur_in       = start_ff;
                  dead_in      = 1'b0;
                  fresh_in     = 1'b1;
               end
            end
         end
         default: begin
            state_in = dfa_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dfa_pkg::ST_IDLE;
         cur_ff       <= '0;
         dead_ff      <= 1'b0;
         fresh_ff     <= 1'b1;
         row_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
         start_ff     <= '0;
         mask_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         dead_ff      <= dead_in;
         fresh_ff     <= fresh_in;
         row_valid_ff <= row_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               dfa_pkg::CSR_START:  start_ff <= csr_ch.data[NODE_W-1:0];
               dfa_pkg::CSR_ACCEPT: mask_ff  <= csr_ch.data[dfa_pkg::MASK_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      dend_ff  <= dend_in;
      fnode_ff <= fnode_in;
      if (accept) begin
         op_ff       <= req_ch.op;
         last_ff     <= req_ch.last;
         sym_ff      <= SYMBOL_BITS'(req_ch.symbol);
         eslot_ff    <= req_ch.edge_slot;
         esym_ff     <= SYMBOL_BITS'(req_ch.edge_symbol);
         enext_ff    <= req_ch.edge_next;
         en_ff       <= req_ch.edge_enable;
         write_ok_ff <= node_ok && (int'(req_ch.edge_slot) < SLOTS) &&
                        (int'(req_ch.edge_next) < NODES);
         node_ff     <= look_node;
         addr_ff     <= rd_addr;
         row_live_ff <= node_ok && row_valid_ff[rd_addr];
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.accepted   = acc_ff;
   assign rsp_ch.dead_end   = dend_ff;
   assign rsp_ch.final_node = fnode_ff;

endmodule

// ===== rtl/dfa_acceptor_checker.sv =====
// port-level assertions for the automaton acceptor, bound to dfa_acceptor_unit
// depends on dfa_pkg; the bind reaches the channel interfaces of dfa_acceptor_unit
module dfa_acceptor_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic                       rsp_accepted,
   input logic                       rsp_dead_end,
   input logic [dfa_pkg::NODE_W-1:0] rsp_final_node
);

   // ready is low once an item has been taken, so items are never taken back to back
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken in the cycle after a transfer");

   // a fresh result is only produced while an item is being evaluated
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared without an item in evaluation");

   // a dead string never accepts and reports node zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_dead_end) |-> (!rsp_accepted && (rsp_final_node == '0)))
      else $error("dead result with accept or nonzero node");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_accepted) &&
                                     $stable(rsp_dead_end) && $stable(rsp_final_node)))
      else $error("stalled result changed");

endmodule

bind dfa_acceptor_unit dfa_acceptor_checker u_dfa_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_accepted   (rsp_ch.accepted),
   .rsp_dead_end   (rsp_ch.dead_end),
   .rsp_final_node (rsp_ch.final_node)
);
